### rtl/core/l2dhc_pkg.sv
// shared types, codes and defaults of the l2 directory home controller
`timescale 1ns / 1ps
package l2dhc_pkg;

  localparam int ADDR_W = 42;
  localparam int TYPE_W = 3;
  localparam int CORE_W = 3;

  localparam int DEF_NUM_SETS  = 4096;
  localparam int DEF_NUM_WAYS  = 16;
  localparam int DEF_NUM_CORES = 8;
  localparam int DEF_AGE_BITS  = 16;

  localparam logic [TYPE_W-1:0] OP_GET   = 3'd0;
  localparam logic [TYPE_W-1:0] OP_GETX  = 3'd1;
  localparam logic [TYPE_W-1:0] OP_UPG   = 3'd2;
  localparam logic [TYPE_W-1:0] OP_DROP  = 3'd3;
  localparam logic [TYPE_W-1:0] OP_REPL  = 3'd4;

  localparam logic [TYPE_W-1:0] MSG_PUT      = 3'd0;
  localparam logic [TYPE_W-1:0] MSG_PUTX     = 3'd1;
  localparam logic [TYPE_W-1:0] MSG_INV      = 3'd2;
  localparam logic [TYPE_W-1:0] MSG_XFER     = 3'd3;
  localparam logic [TYPE_W-1:0] MSG_XFER_INV = 3'd4;
  localparam logic [TYPE_W-1:0] MSG_BACK_INV = 3'd5;

  typedef struct packed {
    logic [TYPE_W-1:0] op;
    logic [CORE_W-1:0] core;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic full;
    logic busy;
  } front_stat_t;

endpackage

### rtl/core/l2dhc_front.sv
// request intake: filters unused request types and cores, pushes the rest
`timescale 1ns / 1ps
module l2dhc_front #(
  parameter int NUM_CORES = l2dhc_pkg::DEF_NUM_CORES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [l2dhc_pkg::TYPE_W-1:0] in_req_type,
  input  logic [l2dhc_pkg::CORE_W-1:0] in_req_core,
  input  logic [l2dhc_pkg::ADDR_W-1:0] in_block_addr,
  input  l2dhc_pkg::front_stat_t     stat,
  output logic                       push,
  output l2dhc_pkg::req_t            push_req
);
  import l2dhc_pkg::*;

  logic legal;
  logic seen_r;

  assign legal = (in_req_type <= OP_REPL) && (int'(in_req_core) < NUM_CORES);
  assign in_stall = stat.full || stat.busy;
  assign push = in_valid && !in_stall && legal;
  assign push_req = '{op: in_req_type, core: in_req_core, addr: in_block_addr};

  // dropped item marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= in_valid && !in_stall && !legal;
    end
  end

  ap_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !push) else $error("push while clearing");
  ap_drop_nopush: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> !$past(push)) else $error("illegal item pushed");
  ap_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> in_stall) else $error("accept while full");

endmodule

### rtl/core/l2dhc_queue.sv
// two entry request queue between intake and the directory engine
`timescale 1ns / 1ps
module l2dhc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  l2dhc_pkg::req_t push_req,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output l2dhc_pkg::req_t q_req
);
  import l2dhc_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_full  = (cnt_r == 2'd2);
  assign q_req   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push) else $error("queue overflow");
  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop) else $error("queue underflow");
  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad queue count");

endmodule

### rtl/core/l2dhc_back.sv
// directory engine: tag and directory lookup, replacement, message sequencing
`timescale 1ns / 1ps
module l2dhc_back #(
  parameter int NUM_SETS  = l2dhc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS  = l2dhc_pkg::DEF_NUM_WAYS,
  parameter int NUM_CORES = l2dhc_pkg::DEF_NUM_CORES,
  parameter int AGE_BITS  = l2dhc_pkg::DEF_AGE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  l2dhc_pkg::req_t             q_req,
  output logic                        pop,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [l2dhc_pkg::TYPE_W-1:0] out_msg_type,
  output logic [l2dhc_pkg::CORE_W-1:0] out_dest_core,
  output logic [l2dhc_pkg::CORE_W-1:0] out_target_core,
  output logic [l2dhc_pkg::ADDR_W-1:0] out_msg_addr,
  output logic                        out_l2_miss,
  output logic                        out_last
);
  import l2dhc_pkg::*;

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int TAG_W = ADDR_W - SET_W;
  localparam int NC    = NUM_CORES;
  localparam int AW    = AGE_BITS;
  localparam int CI_W  = $clog2(NUM_CORES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [NUM_WAYS-1:0]       mem_valid [NUM_SETS];
  logic [NUM_WAYS*TAG_W-1:0] mem_tag   [NUM_SETS];
  logic [NUM_WAYS*AW-1:0]    mem_age   [NUM_SETS];
  logic [NUM_WAYS-1:0]       mem_pres  [NUM_SETS];
  logic [NUM_WAYS-1:0]       mem_mod   [NUM_SETS];
  logic [NUM_WAYS*NC-1:0]    mem_shr   [NUM_SETS];

  logic [NUM_WAYS-1:0]       rd_valid, wr_valid;
  logic [NUM_WAYS*TAG_W-1:0] rd_tag, wr_tag;
  logic [NUM_WAYS*AW-1:0]    rd_age, wr_age;
  logic [NUM_WAYS-1:0]       rd_pres, wr_pres;
  logic [NUM_WAYS-1:0]       rd_mod, wr_mod;
  logic [NUM_WAYS*NC-1:0]    rd_shr, wr_shr;
  logic                      rd_en, wr_en;
  logic [SET_W-1:0]          wr_addr;

  logic [2:0]        st_r, st_nxt;
  logic [SET_W-1:0]  clr_r, clr_nxt;
  req_t              req_r, req_nxt;
  logic [NC-1:0]     mask_r, mask_nxt;
  logic [TYPE_W-1:0] mt_r, mt_nxt, ft_r, ft_nxt;
  logic [CORE_W-1:0] fd_r, fd_nxt, fg_r, fg_nxt;
  logic [ADDR_W-1:0] maddr_r, maddr_nxt;
  logic              miss_r, miss_nxt;
  logic [WAY_W-1:0]  si_r, si_nxt, bw_r, bw_nxt, fw_r, fw_nxt;
  logic [AW-1:0]     best_r, best_nxt;

  logic              ov_r, ov_nxt, olast_r, olast_nxt, omiss_r, omiss_nxt;
  logic [TYPE_W-1:0] otype_r, otype_nxt;
  logic [CORE_W-1:0] odest_r, odest_nxt, otgt_r, otgt_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic              out_load;

  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  logic [NC-1:0]     me;
  logic [NUM_WAYS-1:0] hit_vec;
  logic              hit, any_inv;
  logic [WAY_W-1:0]  hw, inv_w;
  logic              h_pres, h_mod;
  logic [NC-1:0]     h_shr, s_drop;
  logic [CI_W-1:0]   owner, low_m;
  logic [AW-1:0]     scan_age;

  function automatic logic [NUM_WAYS*AW-1:0] touch(input logic [NUM_WAYS*AW-1:0] ages,
                                                    input logic [NUM_WAYS-1:0] vld,
                                                    input logic [WAY_W-1:0] w);
    logic [NUM_WAYS*AW-1:0] r;
    r = ages;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (i == int'(w)) begin
        r[i*AW +: AW] = '0;
      end else if (vld[i] && (ages[i*AW +: AW] != {AW{1'b1}})) begin
        r[i*AW +: AW] = ages[i*AW +: AW] + AW'(1);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_tag[wr_addr]   <= wr_tag;
      mem_age[wr_addr]   <= wr_age;
      mem_pres[wr_addr]  <= wr_pres;
      mem_mod[wr_addr]   <= wr_mod;
      mem_shr[wr_addr]   <= wr_shr;
    end
    if (rd_en) begin
      rd_valid <= mem_valid[q_req.addr[SET_W-1:0]];
      rd_tag   <= mem_tag[q_req.addr[SET_W-1:0]];
      rd_age   <= mem_age[q_req.addr[SET_W-1:0]];
      rd_pres  <= mem_pres[q_req.addr[SET_W-1:0]];
      rd_mod   <= mem_mod[q_req.addr[SET_W-1:0]];
      rd_shr   <= mem_shr[q_req.addr[SET_W-1:0]];
    end
  end

  assign req_set = req_r.addr[SET_W-1:0];
  assign req_tag = req_r.addr[ADDR_W-1:SET_W];
  assign me      = NC'(1) << req_r.core;

  always_comb begin
    hw = '0;
    inv_w = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      hit_vec[i] = rd_valid[i] && (rd_tag[i*TAG_W +: TAG_W] == req_tag);
      if (hit_vec[i]) hw = WAY_W'(i);
      if (!rd_valid[i]) inv_w = WAY_W'(i);
    end
  end

  assign hit     = |hit_vec;
  assign any_inv = !(&rd_valid);
  assign h_pres  = rd_pres[hw];
  assign h_mod   = rd_mod[hw];
  assign h_shr   = rd_shr[int'(hw)*NC +: NC];
  assign s_drop  = h_shr & ~me;
  assign scan_age = rd_age[int'(si_r)*AW +: AW];

  always_comb begin
    owner = '0;
    low_m = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (h_shr[c]) owner = CI_W'(c);
      if (mask_r[c]) low_m = CI_W'(c);
    end
  end

  assign out_load = !ov_r || !out_stall;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; req_nxt = req_r;
    mask_nxt = mask_r; mt_nxt = mt_r; ft_nxt = ft_r; fd_nxt = fd_r; fg_nxt = fg_r;
    maddr_nxt = maddr_r; miss_nxt = miss_r;
    si_nxt = si_r; bw_nxt = bw_r; fw_nxt = fw_r; best_nxt = best_r;
    otype_nxt = otype_r; odest_nxt = odest_r; otgt_nxt = otgt_r;
    oaddr_nxt = oaddr_r; omiss_nxt = omiss_r; olast_nxt = olast_r;
    ov_nxt = out_load ? 1'b0 : ov_r;
    rd_en = 1'b0; wr_en = 1'b0; pop = 1'b0; wr_addr = req_set;
    wr_valid = rd_valid; wr_tag = rd_tag; wr_age = rd_age;
    wr_pres = rd_pres; wr_mod = rd_mod; wr_shr = rd_shr;
    case (st_r)
      ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_r;
        wr_valid = '0; wr_age = '0; wr_pres = '0; wr_mod = '0; wr_shr = '0;
        clr_nxt = clr_r + SET_W'(1);
        if (clr_r == SET_W'(NUM_SETS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1; rd_en = 1'b1; req_nxt = q_req; st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        mask_nxt = '0; mt_nxt = MSG_INV; maddr_nxt = req_r.addr; miss_nxt = 1'b0;
        fd_nxt = req_r.core; fg_nxt = '0;
        ft_nxt = (req_r.op == OP_GET) ? MSG_PUT : MSG_PUTX;
        st_nxt = ST_IDLE;
        case (req_r.op)
          OP_DROP, OP_REPL: begin
            if (hit && h_pres) begin
              wr_en = 1'b1;
              if (((req_r.op == OP_REPL) && h_mod) || (s_drop == '0)) begin
                wr_pres[hw] = 1'b0; wr_mod[hw] = 1'b0; wr_shr[int'(hw)*NC +: NC] = '0;
              end else begin
                wr_shr[int'(hw)*NC +: NC] = s_drop;
              end
            end
          end
          OP_UPG: begin
            if (hit && h_pres) begin
              wr_en = 1'b1; wr_mod[hw] = 1'b1; wr_shr[int'(hw)*NC +: NC] = me;
              st_nxt = ST_EMIT;
              if (!h_mod) begin
                mask_nxt = h_shr; ft_nxt = MSG_PUTX;
              end else begin
                ft_nxt = MSG_XFER_INV; fd_nxt = CORE_W'(owner); fg_nxt = req_r.core;
              end
            end
          end
          default: begin
            if (hit) begin
              wr_en = 1'b1; st_nxt = ST_EMIT;
              if (!h_pres) begin
                wr_age = touch(rd_age, rd_valid, hw);
                wr_pres[hw] = 1'b1; wr_mod[hw] = 1'b1; wr_shr[int'(hw)*NC +: NC] = me;
              end else if (!h_mod) begin
                wr_age = touch(rd_age, rd_valid, hw);
                if (req_r.op == OP_GET) begin
                  wr_shr[int'(hw)*NC +: NC] = h_shr | me;
                end else begin
                  mask_nxt = h_shr; wr_mod[hw] = 1'b1; wr_shr[int'(hw)*NC +: NC] = me;
                end
              end else begin
                fd_nxt = CORE_W'(owner); fg_nxt = req_r.core;
                if (req_r.op == OP_GET) begin
                  ft_nxt = MSG_XFER; wr_mod[hw] = 1'b0;
                  wr_shr[int'(hw)*NC +: NC] = h_shr | me;
                end else begin
                  ft_nxt = MSG_XFER_INV; wr_shr[int'(hw)*NC +: NC] = me;
                end
              end
            end else if (any_inv) begin
              fw_nxt = inv_w; st_nxt = ST_FILL;
            end else begin
              si_nxt = '0; st_nxt = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if ((si_r == '0) || (scan_age > best_r)) begin
          best_nxt = scan_age; bw_nxt = si_r;
        end
        if (si_r == WAY_W'(NUM_WAYS - 1)) begin
          fw_nxt = ((si_r == '0) || (scan_age > best_r)) ? si_r : bw_r;
          st_nxt = ST_FILL;
        end else begin
          si_nxt = si_r + WAY_W'(1);
        end
      end
      ST_FILL: begin
        mask_nxt = rd_pres[fw_r] ? rd_shr[int'(fw_r)*NC +: NC] : '0;
        mt_nxt = MSG_BACK_INV;
        maddr_nxt = {rd_tag[int'(fw_r)*TAG_W +: TAG_W], req_set};
        miss_nxt = 1'b1;
        wr_en = 1'b1;
        wr_valid[fw_r] = 1'b1;
        wr_tag[int'(fw_r)*TAG_W +: TAG_W] = req_tag;
        wr_age = touch(rd_age, rd_valid, fw_r);
        wr_pres[fw_r] = 1'b1; wr_mod[fw_r] = 1'b1; wr_shr[int'(fw_r)*NC +: NC] = me;
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          ov_nxt = 1'b1; omiss_nxt = miss_r;
          if (mask_r != '0) begin
            otype_nxt = mt_r; odest_nxt = CORE_W'(low_m); otgt_nxt = '0;
            oaddr_nxt = maddr_r; olast_nxt = 1'b0;
            mask_nxt = mask_r & ~(NC'(1) << low_m);
          end else begin
            otype_nxt = ft_r; odest_nxt = fd_r; otgt_nxt = fg_r;
            oaddr_nxt = req_r.addr; olast_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; mask_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; mask_r <= mask_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; mt_r <= mt_nxt; ft_r <= ft_nxt; fd_r <= fd_nxt; fg_r <= fg_nxt;
    maddr_r <= maddr_nxt; miss_r <= miss_nxt;
    si_r <= si_nxt; bw_r <= bw_nxt; fw_r <= fw_nxt; best_r <= best_nxt;
    otype_r <= otype_nxt; odest_r <= odest_nxt; otgt_r <= otgt_nxt;
    oaddr_r <= oaddr_nxt; omiss_r <= omiss_nxt; olast_r <= olast_nxt;
  end

  assign busy            = (st_r == ST_CLEAR);
  assign out_valid       = ov_r;
  assign out_msg_type    = otype_r;
  assign out_dest_core   = odest_r;
  assign out_target_core = otgt_r;
  assign out_msg_addr    = oaddr_r;
  assign out_l2_miss     = omiss_r;
  assign out_last        = olast_r;

  ap_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !ov_r) else $error("item during clearing pass");
  ap_idle_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (mask_r == '0)) else $error("pending sharers in idle");
  ap_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (&rd_valid)) else $error("lru scan on set with free way");
  ap_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == ST_IDLE)) else $error("pop outside idle");

endmodule

### rtl/core/l2_directory_home_controller_unit.sv
// top level of the l2 directory home controller
//
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_req_type, in_req_core, in_block_addr
// out     | output    | out_valid, out_stall, out_msg_type, out_dest_core,
//         |           | out_target_core, out_msg_addr, out_l2_miss, out_last
//
// after reset a clearing pass over all NUM_SETS rows (4096 by default) sweeps the tag
// and directory memory; in_stall stays high during it
// a request is read from its row in idle and looked up in look, where a hit is written
// back; a miss adds a fill step, on a full set after an lru scan of NUM_WAYS ways, and
// messages then go out in emit, where a message waiting on out_stall holds its request
// the two entry queue lets intake run ahead while messages wait on out_stall
`timescale 1ns / 1ps
module l2_directory_home_controller_unit #(
  parameter int NUM_SETS  = l2dhc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS  = l2dhc_pkg::DEF_NUM_WAYS,
  parameter int NUM_CORES = l2dhc_pkg::DEF_NUM_CORES,
  parameter int AGE_BITS  = l2dhc_pkg::DEF_AGE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [l2dhc_pkg::TYPE_W-1:0] in_req_type,
  input  logic [l2dhc_pkg::CORE_W-1:0] in_req_core,
  input  logic [l2dhc_pkg::ADDR_W-1:0] in_block_addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [l2dhc_pkg::TYPE_W-1:0] out_msg_type,
  output logic [l2dhc_pkg::CORE_W-1:0] out_dest_core,
  output logic [l2dhc_pkg::CORE_W-1:0] out_target_core,
  output logic [l2dhc_pkg::ADDR_W-1:0] out_msg_addr,
  output logic                         out_l2_miss,
  output logic                         out_last
);
  import l2dhc_pkg::*;

  front_stat_t stat;
  logic        push, pop, q_valid, q_full, busy;
  req_t        push_req, q_req;

  assign stat = '{full: q_full, busy: busy};

  l2dhc_front #(.NUM_CORES(NUM_CORES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_req_core(in_req_core), .in_block_addr(in_block_addr),
    .stat(stat), .push(push), .push_req(push_req)
  );

  l2dhc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req), .pop(pop),
    .q_valid(q_valid), .q_full(q_full), .q_req(q_req)
  );

  l2dhc_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .NUM_CORES(NUM_CORES), .AGE_BITS(AGE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .pop(pop), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall), .out_msg_type(out_msg_type),
    .out_dest_core(out_dest_core), .out_target_core(out_target_core),
    .out_msg_addr(out_msg_addr), .out_l2_miss(out_l2_miss), .out_last(out_last)
  );

endmodule

### bench/l2_directory_home_controller_unit_tb.sv
// testbench of the l2 directory home controller: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module l2_directory_home_controller_unit_tb;
  import l2dhc_pkg::*;

  localparam int SETS = DEF_NUM_SETS;
  localparam int WAYS = DEF_NUM_WAYS;
  localparam int CORES = DEF_NUM_CORES;
  localparam int SET_W = $clog2(SETS);
  localparam int TAG_W = ADDR_W - SET_W;
  localparam int LINES = SETS * WAYS;
  localparam logic [15:0] AGE_TOP = 16'hFFFF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [TYPE_W-1:0] msg_type;
    logic [CORE_W-1:0] dest_core;
    logic [CORE_W-1:0] target_core;
    logic [ADDR_W-1:0] msg_addr;
    logic              l2_miss;
    logic              last;
  } coh_msg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TYPE_W-1:0] in_req_type = '0;
  logic [CORE_W-1:0] in_req_core = '0;
  logic [ADDR_W-1:0] in_block_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TYPE_W-1:0] out_msg_type;
  logic [CORE_W-1:0] out_dest_core;
  logic [CORE_W-1:0] out_target_core;
  logic [ADDR_W-1:0] out_msg_addr;
  logic out_l2_miss;
  logic out_last;

  bit             tag_valid [LINES];
  bit [TAG_W-1:0] tag_store [LINES];
  bit [15:0]      lru_age [LINES];
  bit             entry_present [LINES];
  bit             entry_modified [LINES];
  bit [CORES-1:0] sharer_map [LINES];

  coh_msg_t pending_msgs[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  l2_directory_home_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_req_core(in_req_core), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_msg_type(out_msg_type),
    .out_dest_core(out_dest_core), .out_target_core(out_target_core),
    .out_msg_addr(out_msg_addr), .out_l2_miss(out_l2_miss), .out_last(out_last)
  );

  always #1 clk = ~clk;

  function automatic void push_msg(logic [TYPE_W-1:0] mt, int dest, int target,
                                   logic [ADDR_W-1:0] a, logic miss);
    coh_msg_t m;
    m.msg_type = mt;
    m.dest_core = CORE_W'(dest);
    m.target_core = CORE_W'(target);
    m.msg_addr = a;
    m.l2_miss = miss;
    m.last = 1'b0;
    pending_msgs.insert(pending_msgs.size(), m);
  endfunction

  function automatic void push_to_sharers(logic [TYPE_W-1:0] mt, bit [CORES-1:0] map,
                                          logic [ADDR_W-1:0] a, logic miss);
    for (int c = 0; c < CORES; c++)
      if (map[c]) push_msg(mt, c, 0, a, miss);
  endfunction

  function automatic int owner_core(bit [CORES-1:0] map);
    for (int c = 0; c < CORES; c++)
      if (map[c]) return c;
    return 0;
  endfunction

  function automatic void touch_way(int base, int way);
    for (int i = 0; i < WAYS; i++) begin
      if (i == way) lru_age[base + i] = '0;
      else if (tag_valid[base + i] && lru_age[base + i] != AGE_TOP)
        lru_age[base + i] = lru_age[base + i] + 1'b1;
    end
  endfunction

  function automatic void clear_entry(int k);
    entry_present[k] = 1'b0;
    entry_modified[k] = 1'b0;
    sharer_map[k] = '0;
  endfunction

  function automatic void predict_coherence(logic [TYPE_W-1:0] op, logic [CORE_W-1:0] core,
                                            logic [ADDR_W-1:0] a);
    int set_idx;
    int base;
    int k;
    int w;
    int start;
    bit hit;
    bit found;
    bit [CORES-1:0] me;
    bit [15:0] best;
    logic [ADDR_W-1:0] ev;
    set_idx = int'(a[SET_W-1:0]);
    base = set_idx * WAYS;
    k = 0;
    w = 0;
    hit = 1'b0;
    start = pending_msgs.size();
    if (op > OP_REPL || int'(core) >= CORES) return;
    me = CORES'(1) << core;
    for (int i = 0; i < WAYS; i++)
      if (!hit && tag_valid[base + i] && tag_store[base + i] == a[ADDR_W-1:SET_W]) begin
        hit = 1'b1;
        k = base + i;
        w = i;
      end
    if (op == OP_DROP || op == OP_REPL) begin
      if (hit && entry_present[k]) begin
        if (op == OP_REPL && entry_modified[k]) clear_entry(k);
        else begin
          sharer_map[k] &= ~me;
          if (sharer_map[k] == '0) clear_entry(k);
        end
      end
      return;
    end
    if (op == OP_UPG) begin
      if (!hit || !entry_present[k]) return;
      if (!entry_modified[k]) begin
        push_to_sharers(MSG_INV, sharer_map[k], a, 1'b0);
        push_msg(MSG_PUTX, core, 0, a, 1'b0);
      end else begin
        push_msg(MSG_XFER_INV, owner_core(sharer_map[k]), core, a, 1'b0);
      end
      entry_modified[k] = 1'b1;
      sharer_map[k] = me;
    end else if (hit) begin
      if (!entry_present[k]) begin
        touch_way(base, w);
        entry_present[k] = 1'b1;
        entry_modified[k] = 1'b1;
        sharer_map[k] = me;
        push_msg(op == OP_GET ? MSG_PUT : MSG_PUTX, core, 0, a, 1'b0);
      end else if (!entry_modified[k]) begin
        touch_way(base, w);
        if (op == OP_GET) begin
          sharer_map[k] |= me;
          push_msg(MSG_PUT, core, 0, a, 1'b0);
        end else begin
          push_to_sharers(MSG_INV, sharer_map[k], a, 1'b0);
          entry_modified[k] = 1'b1;
          sharer_map[k] = me;
          push_msg(MSG_PUTX, core, 0, a, 1'b0);
        end
      end else begin
        if (op == OP_GET) begin
          push_msg(MSG_XFER, owner_core(sharer_map[k]), core, a, 1'b0);
          sharer_map[k] |= me;
          entry_modified[k] = 1'b0;
        end else begin
          push_msg(MSG_XFER_INV, owner_core(sharer_map[k]), core, a, 1'b0);
          sharer_map[k] = me;
        end
      end
    end else begin
      found = 1'b0;
      for (int i = 0; i < WAYS; i++)
        if (!found && !tag_valid[base + i]) begin
          w = i;
          found = 1'b1;
        end
      if (!found) begin
        best = '0;
        w = 0;
        for (int i = 0; i < WAYS; i++)
          if (i == 0 || lru_age[base + i] > best) begin
            best = lru_age[base + i];
            w = i;
          end
        if (entry_present[base + w]) begin
          ev = {tag_store[base + w], a[SET_W-1:0]};
          push_to_sharers(MSG_BACK_INV, sharer_map[base + w], ev, 1'b1);
        end
      end
      k = base + w;
      tag_valid[k] = 1'b1;
      tag_store[k] = a[ADDR_W-1:SET_W];
      touch_way(base, w);
      entry_present[k] = 1'b1;
      entry_modified[k] = 1'b1;
      sharer_map[k] = me;
      push_msg(op == OP_GET ? MSG_PUT : MSG_PUTX, core, 0, a, 1'b1);
    end
    if (pending_msgs.size() > start) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
  endfunction

  task automatic send_req(logic [TYPE_W-1:0] op, logic [CORE_W-1:0] core,
                          logic [ADDR_W-1:0] a);
    in_valid <= 1'b1;
    in_req_type <= op;
    in_req_core <= core;
    in_block_addr <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_coherence(op, core, a);
    if (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] full_rand_addr();
    return {10'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [ADDR_W-1:0] pool_addr(int set_idx, int tag_idx);
    return {TAG_W'(tag_idx), SET_W'(set_idx)};
  endfunction

  task automatic test_directed();
    logic [ADDR_W-1:0] a;
    a = pool_addr(7, 3);
    send_req(OP_GET, 0, a);
    send_req(OP_GET, 1, a);
    send_req(OP_GETX, 2, a);
    send_req(OP_GET, 2, a);
    send_req(OP_GET, 5, a);
    send_req(OP_UPG, 6, a);
    send_req(OP_UPG, 3, a);
    send_req(OP_GETX, 3, a);
    send_req(OP_REPL, 4, a);
    send_req(OP_GETX, 4, a);
    send_req(OP_GET, 1, a);
    send_req(OP_DROP, 1, a);
    send_req(OP_DROP, 4, a);
    send_req(OP_UPG, 0, a);
    send_req(OP_DROP, 0, pool_addr(9, 1));
    send_req(OP_UPG, 0, pool_addr(9, 1));
    send_req(3'd5, 7, a);
    send_req(3'd6, 7, a);
    send_req(3'd7, 7, a);
    send_req(OP_GETX, 7, {ADDR_W{1'b1}});
    send_req(OP_GET, 0, '0);
    send_req(OP_REPL, 7, {ADDR_W{1'b1}});
  endtask

  task automatic test_eviction();
    for (int c = 0; c < CORES; c++) send_req(OP_GET, CORE_W'(c), pool_addr(SETS - 1, 0));
    for (int t = 1; t <= WAYS; t++) send_req(OP_GETX, CORE_W'(t), pool_addr(SETS - 1, t));
  endtask

  task automatic test_random_mix(int count);
    int sent;
    int pick;
    logic [TYPE_W-1:0] op;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      op = TYPE_W'($urandom_range(0, 4));
      if (pick < 5) begin
        send_req(TYPE_W'($urandom_range(5, 7)), CORE_W'($urandom), full_rand_addr());
      end else if (pick < 15) begin
        send_req(op, CORE_W'($urandom), full_rand_addr());
        sent++;
      end else begin
        if ($urandom_range(99) < 45) op = $urandom_range(1) ? OP_GET : OP_GETX;
        send_req(op, CORE_W'($urandom),
                 pool_addr($urandom_range(0, 3), $urandom_range(0, 20)));
        sent++;
      end
    end
  endtask

  task automatic test_quiet_stretch();
    quiet = 1'b1;
    test_random_mix(80);
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random_mix(60);
    wait_drained();
    test_random_mix(60);
  endtask

  always @(posedge clk) begin
    coh_msg_t got;
    coh_msg_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_msg_type, out_dest_core, out_target_core, out_msg_addr,
                out_l2_miss, out_last};
        if (pending_msgs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected message %p", got);
        end else begin
          want = pending_msgs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch type %0d/%0d dest %0d/%0d target %0d/%0d addr %h/%h miss %0d/%0d last %0d/%0d",
                       want.msg_type, got.msg_type, want.dest_core, got.dest_core,
                       want.target_core, got.target_core, want.msg_addr, got.msg_addr,
                       want.l2_miss, got.l2_miss, want.last, got.last);
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_eviction();
    test_quiet_stretch();
    test_drain_pause();
    test_random_mix(300);
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_msgs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
